// ===== rtl/csh_pkg.sv =====
// shared constants and types for the closest sphere hit block
package csh_pkg;

    localparam int MAX_SPHERES_DEF = 16;
    localparam int COUNT_W         = 5;
    localparam int IDX_W           = 4;
    localparam int SQRT_STEPS      = 32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [IDX_W-1:0]   entry_index;
        logic               is_sphere;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic [14:0]        radius;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_distance;
        logic [IDX_W-1:0] hit_entry;
    } t_out_item;

    // sphere record as stored in the table
    typedef struct packed {
        logic               is_sphere;
        logic [14:0]        radius;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } t_sphere;

    // work handed from cell to cell
    typedef struct packed {
        logic        vld;
        logic        miss;
        logic [IDX_W-1:0] idx;
        logic [63:0] rem;
        logic [63:0] root;
        logic signed [35:0] p;
    } t_sqrt_tok;

endpackage

// ===== rtl/csh_if.sv =====
// valid / ready channel interfaces for input and result transactions
interface csh_in_if;
    logic              valid;
    logic              ready;
    csh_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface csh_out_if;
    logic               valid;
    logic               ready;
    csh_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/csh_sqrt_cell.sv =====
// one cell of the square root chain: one result bit per cell
module csh_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  csh_pkg::t_sqrt_tok   i_tok,
    output csh_pkg::t_sqrt_tok   o_tok
);
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    csh_pkg::t_sqrt_tok r_tok;
    csh_pkg::t_sqrt_tok n_tok;
    logic [63:0]        trial;

    // restoring square root step
    always_comb begin
        n_tok = i_tok;
        trial = i_tok.root + BIT;
        if (i_tok.rem >= trial) begin
            n_tok.rem  = i_tok.rem - trial;
            n_tok.root = (i_tok.root >> 1) + BIT;
        end else begin
            n_tok.root = i_tok.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.miss <= n_tok.miss;
        r_tok.idx  <= n_tok.idx;
        r_tok.rem  <= n_tok.rem;
        r_tok.root <= n_tok.root;
        r_tok.p    <= n_tok.p;
    end

    assign o_tok = r_tok;
endmodule

// ===== rtl/csh_div_cell.sv =====
// one cell of the divider chain: one quotient bit per cell
module csh_div_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [63:0] i_rem,
    input  logic [33:0] i_den,
    input  logic [55:0] i_num,
    input  logic [55:0] i_quo,
    input  logic [3:0]  i_idx,
    input  logic        i_miss,
    output logic        o_vld,
    output logic [63:0] o_rem,
    output logic [33:0] o_den,
    output logic [55:0] o_num,
    output logic [55:0] o_quo,
    output logic [3:0]  o_idx,
    output logic        o_miss
);
    logic [63:0] sh;
    logic [63:0] n_rem;
    logic        take;

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
        sh    = {i_rem[62:0], i_num[55]};
        take  = sh >= {30'd0, i_den};
        n_rem = take ? sh - {30'd0, i_den} : sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_rem  <= n_rem;
        o_den  <= i_den;
        o_num  <= {i_num[54:0], 1'b0};
        o_quo  <= {i_quo[54:0], take};
        o_idx  <= i_idx;
        o_miss <= i_miss;
    end
endmodule

// ===== rtl/closest_sphere_hit_top.sv =====
// top level of the closest sphere hit block
//
// Input channel: one transaction per item. command load writes one table entry;
// command trace casts a ray from the origin and yields one result transaction
// on the output channel with hit, distance (Q10.22, saturating) and entry.
// The user must write the sphere_count register through i_cfg_we / i_cfg_data
// only while idle; the block itself does not enforce this. A trace streams
// the first sphere_count entries (at most MAX_SPHERES), one per cycle, into a
// chain of cells: table read, dot products (2 stages), discriminant (2), a 32
// cell square root chain, root choice, a 56 cell divider chain and a running
// minimum. Traces are handled one at a time: a new trace is accepted only once
// the last one has drained and its result has been taken. Loads, too, wait for
// a trace in flight to finish and for its result to be taken.
// Reset (i_rst_n low, synchronous) empties the chains and the result
// register; the sphere table is not cleared and reads as undefined until
// written. While the receiver stalls the result stays in its register and
// no new transaction is accepted.
module closest_sphere_hit_top #(
    parameter int MAX_SPHERES = csh_pkg::MAX_SPHERES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [csh_pkg::COUNT_W-1:0]  i_cfg_data,
    csh_in_if.sink                       i_in,
    csh_out_if.source                    o_out
);
    localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW = $clog2(MAX_SPHERES + 1);
    localparam int NS = csh_pkg::SQRT_STEPS;
    localparam int ND = 56;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    logic [csh_pkg::COUNT_W-1:0] r_count;
    csh_pkg::t_sphere r_mem [MAX_SPHERES];

    logic signed [15:0] r_dx, r_dy, r_dz;
    logic [CW-1:0] r_issue, r_limit;
    logic [7:0]    r_inflight;

    // table read stage
    logic           r_rd_vld;
    logic [3:0]     r_rd_idx;
    csh_pkg::t_sphere r_rd;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    logic in_acc;
    assign i_in.ready = (r_state == ST_IDLE) && !o_out.valid;
    assign in_acc     = i_in.valid && i_in.ready;

    // table writes
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.data.command == csh_pkg::CMD_LOAD
            && {28'd0, i_in.data.entry_index} < 32'(MAX_SPHERES)) begin
            r_mem[i_in.data.entry_index[AW-1:0]] <= '{
                is_sphere: i_in.data.is_sphere, radius: i_in.data.radius,
                cx: i_in.data.center_x, cy: i_in.data.center_y,
                cz: i_in.data.center_z};
        end
    end

    logic issue;
    logic fin_vld;
    assign issue = (r_state == ST_ISSUE) && (r_issue < r_limit);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_issue    <= '0;
            r_limit    <= '0;
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 8'(issue) - 8'(fin_vld);
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_in.data.command == csh_pkg::CMD_TRACE) begin
                        r_state <= ST_ISSUE;
                        r_issue <= '0;
                        r_limit <= ({27'd0, r_count} > 32'(MAX_SPHERES))
                                   ? CW'(MAX_SPHERES) : CW'(r_count);
                    end
                end
                ST_ISSUE: begin
                    if (issue) begin
                        r_issue <= r_issue + 1'b1;
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_inflight == '0) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dx <= i_in.data.dir_x;
            r_dy <= i_in.data.dir_y;
            r_dz <= i_in.data.dir_z;
        end
    end

    // table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
        end
        r_rd     <= r_mem[r_issue[AW-1:0]];
        r_rd_idx <= 4'(r_issue);
    end

    // stage 1: products
    logic               r1_vld, r1_flag;
    logic [3:0]         r1_idx;
    logic signed [31:0] r1_pc [3];
    logic signed [31:0] r1_aa [3];
    logic signed [31:0] r1_cc [3];
    logic [29:0]        r1_rr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0; else r1_vld <= r_rd_vld;
        r1_flag  <= r_rd.is_sphere;
        r1_idx   <= r_rd_idx;
        r1_pc[0] <= 32'(r_rd.cx) * 32'(r_dx);
        r1_pc[1] <= 32'(r_rd.cy) * 32'(r_dy);
        r1_pc[2] <= 32'(r_rd.cz) * 32'(r_dz);
        r1_aa[0] <= 32'(r_dx) * 32'(r_dx);
        r1_aa[1] <= 32'(r_dy) * 32'(r_dy);
        r1_aa[2] <= 32'(r_dz) * 32'(r_dz);
        r1_cc[0] <= 32'(r_rd.cx) * 32'(r_rd.cx);
        r1_cc[1] <= 32'(r_rd.cy) * 32'(r_rd.cy);
        r1_cc[2] <= 32'(r_rd.cz) * 32'(r_rd.cz);
        r1_rr    <= 30'(r_rd.radius) * 30'(r_rd.radius);
    end

    // stage 2: sums
    logic               r2_vld, r2_flag;
    logic [3:0]         r2_idx;
    logic signed [35:0] r2_p, r2_c;
    logic [33:0]        r2_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0; else r2_vld <= r1_vld;
        r2_flag <= r1_flag;
        r2_idx  <= r1_idx;
        r2_p <= 36'(r1_pc[0]) + 36'(r1_pc[1]) + 36'(r1_pc[2]);
        r2_a <= 34'(unsigned'(r1_aa[0])) + 34'(unsigned'(r1_aa[1]))
              + 34'(unsigned'(r1_aa[2]));
        r2_c <= 36'(unsigned'(r1_cc[0])) + 36'(unsigned'(r1_cc[1]))
              + 36'(unsigned'(r1_cc[2])) - 36'(r1_rr);
    end

    // stage 3: squares for the discriminant, magnitudes fit in 32 bits
    logic               r3_vld, r3_miss;
    logic [3:0]         r3_idx;
    logic signed [35:0] r3_p;
    logic [63:0]        r3_pp, r3_ac;
    logic               r3_cneg;
    logic [33:0]        r3_a;
    logic [31:0]        pabs, cabs;
    always_comb begin
        pabs = r2_p[35] ? 32'(-r2_p) : 32'(r2_p);
        cabs = r2_c[35] ? 32'(-r2_c) : 32'(r2_c);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0; else r3_vld <= r2_vld;
        r3_miss <= !r2_flag || (r2_a == '0);
        r3_idx  <= r2_idx;
        r3_p    <= r2_p;
        r3_a    <= r2_a;
        r3_cneg <= r2_c[35];
        r3_pp   <= 64'(pabs) * 64'(pabs);
        r3_ac   <= 64'(r2_a) * 64'(cabs);
    end

    // stage 4: discriminant
    csh_pkg::t_sqrt_tok sq [NS+1];
    logic [33:0] a_line [NS+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) sq[0].vld <= 1'b0; else sq[0].vld <= r3_vld;
        sq[0].idx  <= r3_idx;
        sq[0].p    <= r3_p;
        sq[0].root <= '0;
        a_line[0]  <= r3_a;
        if (r3_cneg) begin
            sq[0].rem  <= r3_pp + r3_ac;
            sq[0].miss <= r3_miss;
        end else begin
            sq[0].rem  <= r3_pp - r3_ac;
            sq[0].miss <= r3_miss || (r3_pp < r3_ac);
        end
    end

    // square root cell chain, with the divisor carried alongside
    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        csh_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(sq[g]), .o_tok(sq[g+1]));
        always_ff @(posedge i_clk) a_line[g+1] <= a_line[g];
    end

    // choose root
    logic               rc_vld, rc_miss;
    logic [3:0]         rc_idx;
    logic [33:0]        rc_a;
    logic [55:0]        rc_num;
    logic signed [65:0] n_plus, n_minus, n_sel;
    always_comb begin
        n_plus  = 66'(sq[NS].p) + 66'(sq[NS].root);
        n_minus = 66'(sq[NS].p) - 66'(sq[NS].root);
        n_sel   = n_minus[65] ? n_plus : n_minus;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rc_vld <= 1'b0; else rc_vld <= sq[NS].vld;
        rc_miss <= sq[NS].miss || n_plus[65];
        rc_idx  <= sq[NS].idx;
        rc_a    <= a_line[NS];
        rc_num  <= {n_sel[33:0], 22'd0};
    end

    // divider cell chain
    logic        dv_vld [ND+1];
    logic [63:0] dv_rem [ND+1];
    logic [33:0] dv_den [ND+1];
    logic [55:0] dv_num [ND+1];
    logic [55:0] dv_quo [ND+1];
    logic [3:0]  dv_idx [ND+1];
    logic        dv_miss[ND+1];
    assign dv_vld[0]  = rc_vld;
    assign dv_rem[0]  = '0;
    assign dv_den[0]  = rc_a;
    assign dv_num[0]  = rc_num;
    assign dv_quo[0]  = '0;
    assign dv_idx[0]  = rc_idx;
    assign dv_miss[0] = rc_miss;
    for (genvar g = 0; g < ND; g++) begin : g_div
        csh_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(dv_vld[g]), .i_rem(dv_rem[g]), .i_den(dv_den[g]),
            .i_num(dv_num[g]), .i_quo(dv_quo[g]), .i_idx(dv_idx[g]),
            .i_miss(dv_miss[g]),
            .o_vld(dv_vld[g+1]), .o_rem(dv_rem[g+1]), .o_den(dv_den[g+1]),
            .o_num(dv_num[g+1]), .o_quo(dv_quo[g+1]), .o_idx(dv_idx[g+1]),
            .o_miss(dv_miss[g+1]));
    end

    // running minimum, earlier entry wins on ties
    logic [31:0] dist_sat;
    assign fin_vld  = dv_vld[ND];
    assign dist_sat = (dv_quo[ND][55:32] != '0) ? 32'hFFFF_FFFF : dv_quo[ND][31:0];

    logic        r_found;
    logic [31:0] r_best;
    logic [3:0]  r_best_idx;
    logic        r_ovld;
    csh_pkg::t_out_item r_odata;
    logic        done;
    assign done = (r_state == ST_DRAIN) && (r_inflight == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_found <= 1'b0;
            end else if (fin_vld && !dv_miss[ND] && (!r_found || dist_sat < r_best)) begin
                r_found    <= 1'b1;
                r_best     <= dist_sat;
                r_best_idx <= dv_idx[ND];
            end
            if (done) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
        if (done) begin
            r_odata.hit          <= r_found;
            r_odata.hit_distance <= r_found ? r_best : '0;
            r_odata.hit_entry    <= r_found ? r_best_idx : '0;
        end
    end

    assign o_out.valid = r_ovld;
    assign o_out.data  = r_odata;
endmodule
